FILE: hdl/bskc_pkg.sv
// Shared types and constants for the byte stream key cipher.
`default_nettype none

package bskc_pkg;

    // Request command codes
    localparam logic CMD_KEY_LOAD = 1'b0;
    localparam logic CMD_DATA     = 1'b1;

    // Direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // Start pointer scramble constant
    localparam logic [7:0] START_XOR = 8'd223;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_MIX_KEY_A       = 3'd0;
    localparam t_cfg_index CFG_MIX_KEY_B       = 3'd1;
    localparam t_cfg_index CFG_MIX_KEY_C       = 3'd2;
    localparam t_cfg_index CFG_MIX_KEY_D       = 3'd3;
    localparam t_cfg_index CFG_KEY_LENGTH_LOG2 = 3'd4;

    localparam logic [3:0] KEY_LENGTH_LOG2_RST = 4'd4;

    typedef struct packed {
        logic       command;
        logic       direction;
        logic       first;
        logic [7:0] param;
        logic [7:0] data_in;
        logic       last_in;
        logic [7:0] key_address;
        logic [7:0] key_value;
    } t_cipher_req;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_cipher_rsp;

endpackage

`default_nettype wire

FILE: hdl/byte_stream_key_cipher.sv
// Byte stream key cipher: key table, pointer tracking and byte transform.
`default_nettype none

// Byte stream key cipher. Each accepted request either loads one key byte
// (command 0, no response) or encrypts/decrypts one message byte
// (command 1, one response carrying the transformed byte and the last
// mark). Throughput is one request per clock unless responses stall,
// including back-to-back data bytes and key loads mixed with data. An
// accepted data byte moves from the transform stage register into the
// output register once that is free. The accepting edge computes the key
// pointer from the pointer state and captures the key table read; the
// output register takes the registered key byte through the xor/add/mix
// transform. That two-stage split is set by the key table's registered
// read; the pointer update does not depend on the key data, so the next
// byte's read can issue while the current byte is transformed. A stalled
// response holds both stages, and o_req_stall follows i_rsp_stall in the
// same cycle once both stages are full. A key byte written by one request
// is visible to the very next data byte. The key table has no reset and
// no clearing pass; read only entries that were loaded. Key addresses at
// or above MAX_KEY_BYTES are dropped. The first-of-message mark restarts
// the pointer at (param xor 223) masked to the key length and latches
// param for the rest of the message. Write the configuration registers
// only while no request is in flight.
module byte_stream_key_cipher #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // request channel
    input  wire                        i_req_valid,
    output logic                       o_req_stall,
    input  bskc_pkg::t_cipher_req      i_req,
    // response channel
    output logic                       o_rsp_valid,
    input  wire                        i_rsp_stall,
    output bskc_pkg::t_cipher_rsp      o_rsp,
    // configuration write port
    input  wire                        i_cfg_we,
    input  bskc_pkg::t_cfg_index       i_cfg_index,
    input  wire  [7:0]                 i_cfg_data
);

    import bskc_pkg::*;

    // key table address width and largest usable log2 length
    localparam int KEY_AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int MAX_LG2 = $clog2(MAX_KEY_BYTES + 1) - 1;

    // configuration
    logic [7:0] r_mix_a, r_mix_b, r_mix_c, r_mix_d;
    logic [3:0] r_len_log2;

    // message state
    logic [7:0] r_key_ptr, n_key_ptr;
    logic [7:0] r_byte_pos, n_byte_pos;
    logic [7:0] r_msg_param, n_msg_param;

    // key table
    logic [7:0] r_key_mem [MAX_KEY_BYTES];
    logic [7:0] r_key_rd;

    // transform stage
    logic       r_s1_valid;
    logic       r_s1_dir;
    logic       r_s1_last;
    logic [7:0] r_s1_data;
    logic [7:0] r_s1_param;
    logic [7:0] r_s1_ptr;

    // output register
    logic        r_rsp_valid;
    t_cipher_rsp r_rsp;

    // handshake
    logic rsp_free, s1_adv, s1_free, req_acc, data_acc, key_wr;

    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;
    assign s1_adv      = r_s1_valid && rsp_free;
    assign s1_free     = !r_s1_valid || rsp_free;
    assign o_req_stall = !s1_free;
    assign req_acc     = i_req_valid && s1_free;
    assign data_acc    = req_acc && (i_req.command == CMD_DATA);
    assign key_wr      = req_acc && (i_req.command == CMD_KEY_LOAD)
                         && ({1'b0, i_req.key_address} < 9'(MAX_KEY_BYTES));

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_a    <= '0;
            r_mix_b    <= '0;
            r_mix_c    <= '0;
            r_mix_d    <= '0;
            r_len_log2 <= KEY_LENGTH_LOG2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIX_KEY_A:       r_mix_a    <= i_cfg_data;
                CFG_MIX_KEY_B:       r_mix_b    <= i_cfg_data;
                CFG_MIX_KEY_C:       r_mix_c    <= i_cfg_data;
                CFG_MIX_KEY_D:       r_mix_d    <= i_cfg_data;
                CFG_KEY_LENGTH_LOG2: r_len_log2 <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: pointer for this byte, pointer state for the next one.
    // Length is clamped to 2**MAX_LG2 (at most 256).
    // ---------------------------------------------------------------
    logic [3:0] len_lg2;
    logic [7:0] len_mask;
    logic [7:0] cur_ptr, cur_pos, cur_param;

    always_comb begin
        len_lg2  = (r_len_log2 > 4'(MAX_LG2)) ? 4'(MAX_LG2) : r_len_log2;
        len_mask = 8'((9'd1 << len_lg2) - 9'd1);
        if (i_req.first) begin
            cur_ptr   = (i_req.param ^ START_XOR) & len_mask;
            cur_pos   = '0;
            cur_param = i_req.param;
        end else begin
            cur_ptr   = r_key_ptr & len_mask;
            cur_pos   = r_byte_pos;
            cur_param = r_msg_param;
        end
        n_key_ptr   = r_key_ptr;
        n_byte_pos  = r_byte_pos;
        n_msg_param = r_msg_param;
        if (data_acc) begin
            n_key_ptr   = 8'(cur_ptr + cur_pos) & len_mask;
            n_byte_pos  = 8'(cur_pos + 8'd1);
            n_msg_param = cur_param;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_ptr   <= '0;
            r_byte_pos  <= '0;
            r_msg_param <= '0;
        end else begin
            r_key_ptr   <= n_key_ptr;
            r_byte_pos  <= n_byte_pos;
            r_msg_param <= n_msg_param;
        end
    end

    // key table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key_mem[i_req.key_address[KEY_AW-1:0]] <= i_req.key_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_key_rd <= r_key_mem[cur_ptr[KEY_AW-1:0]];
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_s1_dir   <= i_req.direction;
            r_s1_last  <= i_req.last_in;
            r_s1_data  <= i_req.data_in;
            r_s1_param <= cur_param;
            r_s1_ptr   <= cur_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= data_acc;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: byte transform
    // ---------------------------------------------------------------
    logic [7:0]  key_char, key_half, mix_mask, mix_mult, mix_byte, xf_byte;
    logic [15:0] prod_ab, prod_kp, prod_mp;

    always_comb begin
        key_char = r_key_rd ^ r_s1_param;
        key_half = key_char >> 1;
        prod_ab  = r_mix_a * r_mix_b;
        mix_mask = prod_ab[7:0];
        mix_mult = 8'(r_mix_c + r_mix_d);
        prod_kp  = key_char * r_s1_ptr;
        prod_mp  = mix_mult * r_s1_ptr;
        mix_byte = (prod_kp[7:0] & mix_mask) | prod_mp[7:0];
        case (r_s1_dir)
            DIR_ENCRYPT: xf_byte = 8'((r_s1_data ^ key_char) + key_half) ^ mix_byte;
            default:     xf_byte = 8'((r_s1_data ^ mix_byte) - key_half) ^ key_char;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_free) begin
            r_rsp_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rsp.data_out <= xf_byte;
            r_rsp.last_out <= r_s1_last;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_data_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |=> r_s1_valid)
        else $error("accepted data byte did not reach transform stage");

    a_key_load_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.command == CMD_KEY_LOAD) |=> !r_s1_valid)
        else $error("key load produced a transform stage entry");

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_acc && i_req.first) |=> (r_byte_pos == 8'd1))
        else $error("byte position not restarted by first byte");

    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_acc && !i_req.first) |=> (r_byte_pos == 8'($past(r_byte_pos) + 8'd1)))
        else $error("byte position did not advance");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_ptr) && $stable(r_key_rd)))
        else $error("stalled transform stage lost its contents");

endmodule

`default_nettype wire

FILE: tb/byte_stream_key_cipher_tb.sv
// Self-checking testbench for the byte stream key cipher: queued requests, mirror model, checker.
`default_nettype none

module byte_stream_key_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bskc_pkg::*;

    // ------------------------------------------------------------------
    // DUT hookup. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_stall;
    t_cipher_req req_payload = '0;
    logic        rsp_valid;
    logic        rsp_stall   = 1'b0;
    t_cipher_rsp rsp_payload;
    logic        cfg_we      = 1'b0;
    t_cfg_index  cfg_index   = CFG_MIX_KEY_A;
    logic [7:0]  cfg_data    = 8'h00;

    byte_stream_key_cipher uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_payload),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_payload),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // Hang guard: far beyond the slowest legal run (~1.9k requests with
    // heavy stalls on either side).
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher mirror: key table, message pointer state and config copy.
    // Updated at the rising edge where a request or config write lands.
    // ------------------------------------------------------------------
    logic [7:0]  key_mirror [256];
    logic [7:0]  msg_ptr   = 8'h00;
    logic [7:0]  msg_pos   = 8'h00;
    logic [7:0]  msg_param = 8'h00;
    logic [7:0]  mix_a     = 8'h00;
    logic [7:0]  mix_b     = 8'h00;
    logic [7:0]  mix_c     = 8'h00;
    logic [7:0]  mix_d     = 8'h00;
    logic [3:0]  len_log2  = KEY_LENGTH_LOG2_RST;

    t_cipher_rsp predicted_bytes [$];   // transformed bytes still owed by the DUT
    t_cipher_req pending_reqs    [$];   // requests not yet presented
    bit          key_loaded      [256]; // generator side: entries safe to read

    int send_idle_pct = 28;
    int recv_idle_pct = 82;
    int errors        = 0;
    bit req_fire      = 1'b0;           // handshake seen at the last rising edge

    // Key length minus one; lengths past 256 clamp to the full table.
    function automatic logic [7:0] len_mask(input logic [3:0] lg);
        if (lg >= 4'd8)
            return 8'hFF;
        return 8'((9'd1 << lg) - 9'd1);
    endfunction

    // Mirror of one accepted request. Key loads just update the table;
    // data bytes produce one predicted output byte.
    task automatic apply_cipher_request(input t_cipher_req r);
        logic [7:0]  mask;
        logic [7:0]  ptr;
        logic [7:0]  kc;
        logic [7:0]  prod_mask;
        logic [7:0]  step_mult;
        logic [7:0]  mix;
        logic [7:0]  b;
        t_cipher_rsp rsp;
        if (r.command == CMD_KEY_LOAD) begin
            key_mirror[r.key_address] = r.key_value;
            return;
        end
        mask = len_mask(len_log2);
        // first mark restarts the walk and latches the message param
        if (r.first) begin
            msg_param = r.param;
            msg_ptr   = (r.param ^ START_XOR) & mask;
            msg_pos   = 8'h00;
        end
        ptr       = msg_ptr & mask;
        kc        = key_mirror[ptr] ^ msg_param;
        prod_mask = mix_a * mix_b;
        step_mult = mix_c + mix_d;
        mix       = ((kc * ptr) & prod_mask) | (step_mult * ptr);
        b         = r.data_in;
        if (r.direction == DIR_ENCRYPT) begin
            b = b ^ kc;
            b = b + {1'b0, kc[7:1]};
            b = b ^ mix;
        end else begin
            b = b ^ mix;
            b = b - {1'b0, kc[7:1]};
            b = b ^ kc;
        end
        // pointer hops by the running position; position wraps at 256
        msg_ptr = (ptr + msg_pos) & mask;
        msg_pos = msg_pos + 8'd1;
        rsp.data_out = b;
        rsp.last_out = r.last_in;
        predicted_bytes.insert(predicted_bytes.size(), rsp);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents requests at the falling edge. Once valid is up the
    // payload holds until the handshake; idling only decides whether a
    // fresh request goes out, never depends on stall.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end else begin
            if (!req_valid || req_fire) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_payload <= pending_reqs.pop_front();
                    req_valid   <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels and the config port at the rising
    // edge, runs the mirror on accepted requests, checks responses.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_cipher_rsp want;
        req_fire = rst_n && req_valid && !req_stall;
        if (rst_n && cfg_we) begin
            case (cfg_index)
                CFG_MIX_KEY_A:       mix_a    = cfg_data;
                CFG_MIX_KEY_B:       mix_b    = cfg_data;
                CFG_MIX_KEY_C:       mix_c    = cfg_data;
                CFG_MIX_KEY_D:       mix_d    = cfg_data;
                CFG_KEY_LENGTH_LOG2: len_log2 = cfg_data[3:0];
                default: ;
            endcase
        end
        if (req_fire)
            apply_cipher_request(req_payload);
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (predicted_bytes.size() == 0) begin
                $display("%0t: unexpected response, expected none, got data_out=%02h last_out=%0b",
                         $time, rsp_payload.data_out, rsp_payload.last_out);
                errors++;
            end else begin
                want = predicted_bytes.pop_front();
                if (rsp_payload.data_out !== want.data_out) begin
                    $display("%0t: data_out mismatch, expected %02h, got %02h",
                             $time, want.data_out, rsp_payload.data_out);
                    errors++;
                end
                if (rsp_payload.last_out !== want.last_out) begin
                    $display("%0t: last_out mismatch, expected %0b, got %0b",
                             $time, want.last_out, rsp_payload.last_out);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    function automatic t_cipher_req random_request();
        t_cipher_req r;
        r.command     = 1'($urandom_range(1));
        r.direction   = 1'($urandom_range(1));
        r.first       = 1'($urandom_range(1));
        r.param       = 8'($urandom_range(255));
        r.data_in     = 8'($urandom_range(255));
        r.last_in     = 1'($urandom_range(1));
        r.key_address = 8'($urandom_range(255));
        r.key_value   = 8'($urandom_range(255));
        return r;
    endfunction

    // Unused fields stay random so the DUT must really ignore them.
    task automatic push_key(input logic [7:0] addr, input logic [7:0] val);
        t_cipher_req r;
        r             = random_request();
        r.command     = CMD_KEY_LOAD;
        r.key_address = addr;
        r.key_value   = val;
        pending_reqs.insert(pending_reqs.size(), r);
        key_loaded[addr] = 1'b1;
    endtask

    task automatic push_byte(input logic dir, input logic fst, input logic [7:0] prm,
                             input logic [7:0] dat, input logic lst);
        t_cipher_req r;
        r           = random_request();
        r.command   = CMD_DATA;
        r.direction = dir;
        r.first     = fst;
        r.param     = prm;
        r.data_in   = dat;
        r.last_in   = lst;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Fill every entry the pointer can reach at this length, so no data
    // byte ever reads a key entry that was never loaded.
    task automatic load_missing_keys(input logic [3:0] lg);
        int len;
        len = int'(len_mask(lg)) + 1;
        for (int i = 0; i < len; i++)
            if (!key_loaded[i])
                push_key(8'(i), 8'($urandom_range(255)));
    endtask

    // Well-formed message with random content, occasional key reloads
    // mid-message and a few corrupted first/last marks.
    task automatic gen_message(input int n);
        logic dir;
        logic fst;
        logic lst;
        dir = 1'($urandom_range(1));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8)
                push_key(8'($urandom_range(255)), 8'($urandom_range(255)));
            fst = (i == 0);
            lst = (i == n - 1);
            if ($urandom_range(99) < 4)
                fst = ~fst;
            if ($urandom_range(99) < 4)
                lst = ~lst;
            push_byte(dir, fst, 8'($urandom_range(255)), 8'($urandom_range(255)), lst);
        end
    endtask

    // Mostly messages (short, sometimes longer), the rest fully random
    // requests. Once the reachable keys are loaded any request is legal.
    task automatic gen_traffic(input int count);
        int made;
        int n;
        t_cipher_req r;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 85) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                gen_message(n);
                made += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    r = random_request();
                    pending_reqs.insert(pending_reqs.size(), r);
                    if (r.command == CMD_KEY_LOAD)
                        key_loaded[r.key_address] = 1'b1;
                end
                made += n;
            end
        end
    endtask

    // Block is idle: nothing queued or presented, nothing owed, plus a
    // trailing wait for a last key load (two-stage pipeline).
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || predicted_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One phase: drain, set idling and all registers, load keys, queue
    // traffic. With hold set the sender stops halfway until all is back.
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d,
                             input logic [3:0] lg, input int count, input bit hold);
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_cfg(CFG_MIX_KEY_A, a);
        write_cfg(CFG_MIX_KEY_B, b);
        write_cfg(CFG_MIX_KEY_C, c);
        write_cfg(CFG_MIX_KEY_D, d);
        write_cfg(CFG_KEY_LENGTH_LOG2, {4'h0, lg});
        load_missing_keys(lg);
        if (hold) begin
            gen_traffic(count / 2);
            wait_drained();
            gen_traffic(count - count / 2);
        end else begin
            gen_traffic(count);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset config (16 byte key, zero mix keys).
        push_key(8'h00, 8'hFF);
        for (int i = 1; i < 15; i++)
            push_key(8'(i), 8'($urandom_range(255)));
        push_key(8'h0F, 8'h00);
        push_key(8'hFF, 8'hA5);
        // bytes before any first mark run from the reset pointer state
        push_byte(DIR_ENCRYPT, 1'b0, 8'h00, 8'h00, 1'b0);
        push_byte(DIR_DECRYPT, 1'b0, 8'hFF, 8'hFF, 1'b0);
        // message with extreme param and data; param ignored after first
        push_byte(DIR_ENCRYPT, 1'b1, 8'hFF, 8'hFF, 1'b0);
        push_byte(DIR_ENCRYPT, 1'b0, 8'h00, 8'h00, 1'b0);
        push_byte(DIR_DECRYPT, 1'b0, 8'h3C, 8'h5A, 1'b1);
        // single byte message: first and last together
        push_byte(DIR_DECRYPT, 1'b1, 8'h00, 8'h00, 1'b1);
        // param equal to the scramble constant starts at entry zero
        push_byte(DIR_ENCRYPT, 1'b1, START_XOR, 8'h80, 1'b0);
        push_byte(DIR_DECRYPT, 1'b0, 8'h12, 8'h7F, 1'b1);

        // Sender idles lightly, receiver heavily.
        run_phase(28, 82, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 200, 1'b0);
        run_phase(28, 82, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 4'd8, 250, 1'b0);
        // Roles swapped; oversized length clamps to the full table.
        run_phase(82, 28, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15, 250, 1'b1);
        run_phase(82, 28, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 4'd1, 200, 1'b0);
        // No idling; one long message wraps the byte position.
        run_phase(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 4'd5, 150, 1'b0);
        gen_message(300);
        run_phase(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 4'd3, 150, 1'b0);

        wait_drained();
        if (errors == 0 && predicted_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: byte_stream_key_cipher.f
hdl/bskc_pkg.sv
hdl/byte_stream_key_cipher.sv
tb/byte_stream_key_cipher_tb.sv
